FILE: rtl/core/rst_pkg.sv
// ----------------------------------------------------------------------------
// rst_pkg
// Types, codes and constants shared by the running status section parser.
// ----------------------------------------------------------------------------
package rst_pkg;

   localparam int DEF_MIN_SECTION_BYTES = 3;
   localparam int DEF_MAX_SECTION_BYTES = 1024;
   localparam int DEF_MAX_ENTRIES       = 128;

   localparam int RECORD_BYTES      = 9;
   localparam int RECORD_LAST_INDEX = RECORD_BYTES - 1;

   localparam logic [11:0] POS_TABLE_ID  = 12'd0;
   localparam logic [11:0] POS_LENGTH_HI = 12'd1;
   localparam logic [11:0] POS_LENGTH_LO = 12'd2;
   localparam logic [11:0] POS_SATURATED = 12'hFFF;

   localparam logic KIND_ENTRY   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic STATUS_OK         = 1'b0;
   localparam logic STATUS_SIZE_ERROR = 1'b1;

   localparam int RESULT_QUEUE_DEPTH = 4;
   localparam int RQ_PTR_W           = $clog2(RESULT_QUEUE_DEPTH);
   localparam int RQ_CNT_W           = $clog2(RESULT_QUEUE_DEPTH + 1);

   typedef struct packed {
      logic        result_kind;
      logic [15:0] stream_id;
      logic [15:0] network_id;
      logic [15:0] service_number;
      logic [15:0] event_number;
      logic [2:0]  run_state;
      logic [6:0]  entry_index;
      logic [7:0]  table_code;
      logic [11:0] length_field;
      logic [7:0]  entries_found;
      logic        parse_status;
      logic        final_result;
   } result_type;

   typedef struct packed {
      logic       entry_valid;
      logic       summary_valid;
      result_type entry;
      result_type summary;
   } push_type;

endpackage

FILE: rtl/core/rst_parse_core.sv
// ----------------------------------------------------------------------------
// rst_parse_core
// Section state registers and the per-byte parse step; emits up to an entry
// and a summary for each accepted byte.
// ----------------------------------------------------------------------------
module rst_parse_core import rst_pkg::*; #(
   parameter int MIN_SECTION_BYTES = DEF_MIN_SECTION_BYTES,
   parameter int MAX_SECTION_BYTES = DEF_MAX_SECTION_BYTES,
   parameter int MAX_ENTRIES       = DEF_MAX_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  data_byte,
   input  logic        first_byte,
   input  logic        last_byte,
   input  logic [11:0] section_bytes,
   output push_type    push
);

   logic [11:0] pos_ff,   pos_in;
   logic [11:0] rem_ff,   rem_in;
   logic [3:0]  rbi_ff,   rbi_in;
   logic [63:0] shift_ff, shift_in;
   logic [7:0]  tid_ff,   tid_in;
   logic [11:0] len_ff,   len_in;
   logic [7:0]  cnt_ff,   cnt_in;
   logic        err_ff,   err_in;
   logic        open_ff,  open_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         rem_ff   <= '0;
         rbi_ff   <= '0;
         shift_ff <= '0;
         tid_ff   <= '0;
         len_ff   <= '0;
         cnt_ff   <= '0;
         err_ff   <= 1'b0;
         open_ff  <= 1'b0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         rem_ff   <= rem_in;
         rbi_ff   <= rbi_in;
         shift_ff <= shift_in;
         tid_ff   <= tid_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         err_ff   <= err_in;
         open_ff  <= open_in;
      end
   end

   always_comb begin
      logic size_bad;
      logic take_record;
      size_bad = (section_bytes < 12'(MIN_SECTION_BYTES)) ||
                 (section_bytes > 12'(MAX_SECTION_BYTES));

      pos_in   = first_byte ? '0 : pos_ff;
      rem_in   = first_byte ? '0 : rem_ff;
      rbi_in   = first_byte ? '0 : rbi_ff;
      shift_in = first_byte ? '0 : shift_ff;
      tid_in   = first_byte ? '0 : tid_ff;
      len_in   = first_byte ? '0 : len_ff;
      cnt_in   = first_byte ? '0 : cnt_ff;
      err_in   = first_byte ? size_bad : err_ff;
      open_in  = first_byte | open_ff;
      push     = '0;

      take_record = (rbi_in != '0) ||
                    ((rem_in >= 12'(RECORD_BYTES)) && (cnt_in < 8'(MAX_ENTRIES)));

      if (open_in) begin
         if (!err_in) begin
            priority if (pos_in == POS_TABLE_ID) begin
               tid_in = data_byte;
            end else if (pos_in == POS_LENGTH_HI) begin
               len_in = {data_byte[3:0], 8'h00};
            end else if (pos_in == POS_LENGTH_LO) begin
               len_in = {len_in[11:8], data_byte};
               rem_in = {len_in[11:8], data_byte};
            end else if (take_record) begin
               if (rbi_in < 4'(RECORD_LAST_INDEX)) begin
                  shift_in = {shift_in[55:0], data_byte};
                  rbi_in   = rbi_in + 4'd1;
               end else begin
                  push.entry_valid          = 1'b1;
                  push.entry.result_kind    = KIND_ENTRY;
                  push.entry.stream_id      = shift_in[63:48];
                  push.entry.network_id     = shift_in[47:32];
                  push.entry.service_number = shift_in[31:16];
                  push.entry.event_number   = shift_in[15:0];
                  push.entry.run_state      = data_byte[2:0];
                  push.entry.entry_index    = cnt_in[6:0];
                  push.entry.table_code     = tid_in;
                  push.entry.length_field   = len_in;
                  push.entry.entries_found  = cnt_in + 8'd1;
                  push.entry.parse_status   = STATUS_OK;
                  push.entry.final_result   = 1'b0;
                  cnt_in   = cnt_in + 8'd1;
                  rem_in   = rem_in - 12'(RECORD_BYTES);
                  rbi_in   = '0;
                  shift_in = '0;
               end
            end else begin
               rbi_in = rbi_in;
            end
         end
         if (pos_in != POS_SATURATED) begin
            pos_in = pos_in + 12'd1;
         end
         if (last_byte) begin
            push.summary_valid         = 1'b1;
            push.summary.result_kind   = KIND_SUMMARY;
            push.summary.table_code    = tid_in;
            push.summary.length_field  = len_in;
            push.summary.entries_found = cnt_in;
            push.summary.parse_status  = err_in ? STATUS_SIZE_ERROR : STATUS_OK;
            push.summary.final_result  = 1'b1;
            pos_in   = '0;
            rem_in   = '0;
            rbi_in   = '0;
            shift_in = '0;
            tid_in   = '0;
            len_in   = '0;
            cnt_in   = '0;
            err_in   = 1'b0;
            open_in  = 1'b0;
         end
      end
      if (!accept) begin
         push.entry_valid   = 1'b0;
         push.summary_valid = 1'b0;
      end
   end

endmodule

FILE: rtl/core/rst_result_queue.sv
// ----------------------------------------------------------------------------
// rst_result_queue
// Small result queue; takes up to two results a cycle, delivers one.
// ----------------------------------------------------------------------------
module rst_result_queue import rst_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   input  logic       pop,
   output logic       room,
   output logic       not_empty,
   output result_type head
);

   result_type            slot_ff [RESULT_QUEUE_DEPTH];
   logic [RQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RQ_CNT_W-1:0]   count_ff,  count_in;
   logic [RQ_PTR_W-1:0]   wr_next;
   logic [1:0]            n_push;
   result_type            first_data;

   assign n_push     = {1'b0, push.entry_valid} + {1'b0, push.summary_valid};
   assign first_data = push.entry_valid ? push.entry : push.summary;
   assign wr_next    = wr_ptr_ff + RQ_PTR_W'(1);
   assign wr_ptr_in  = wr_ptr_ff + RQ_PTR_W'(n_push);
   assign rd_ptr_in  = rd_ptr_ff + RQ_PTR_W'(pop);
   assign count_in   = count_ff + RQ_CNT_W'(n_push) - RQ_CNT_W'(pop);
   assign room       = count_ff <= RQ_CNT_W'(RESULT_QUEUE_DEPTH - 2);
   assign not_empty  = count_ff != '0;
   assign head       = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         slot_ff[wr_ptr_ff] <= first_data;
      end
      if (push.entry_valid && push.summary_valid) begin
         slot_ff[wr_next] <= push.summary;
      end
   end

endmodule

FILE: rtl/core/rst_section_parser.sv
// ----------------------------------------------------------------------------
// rst_section_parser
// Byte-serial parser for a DVB running status section: header, 9-byte
// running status records, and an end-of-section summary.
// ----------------------------------------------------------------------------
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_stall | one section byte with flags
//   rsp_    | out       | rsp_valid / rsp_stall | entry or summary result
//
// One byte per cycle while req_stall is low; each byte is parsed in the cycle
// it is accepted and its results (up to two) enter a four-deep result queue,
// readable next cycle. Reset is synchronous and clears the section state and
// the queue. req_stall rises while fewer than two queue slots are free.
// ----------------------------------------------------------------------------
module rst_section_parser import rst_pkg::*; #(
   parameter int MIN_SECTION_BYTES = DEF_MIN_SECTION_BYTES,
   parameter int MAX_SECTION_BYTES = DEF_MAX_SECTION_BYTES,
   parameter int MAX_ENTRIES       = DEF_MAX_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   input  logic [11:0] req_section_bytes,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [15:0] rsp_stream_id,
   output logic [15:0] rsp_network_id,
   output logic [15:0] rsp_service_number,
   output logic [15:0] rsp_event_number,
   output logic [2:0]  rsp_run_state,
   output logic [6:0]  rsp_entry_index,
   output logic [7:0]  rsp_table_code,
   output logic [11:0] rsp_length_field,
   output logic [7:0]  rsp_entries_found,
   output logic        rsp_parse_status,
   output logic        rsp_final_result
);

   logic       room;
   logic       accept;
   push_type   push;
   result_type head;

   assign req_stall = !room;
   assign accept    = req_valid && room;

   rst_parse_core #(
      .MIN_SECTION_BYTES (MIN_SECTION_BYTES),
      .MAX_SECTION_BYTES (MAX_SECTION_BYTES),
      .MAX_ENTRIES       (MAX_ENTRIES)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .first_byte    (req_first_byte),
      .last_byte     (req_last_byte),
      .section_bytes (req_section_bytes),
      .push          (push)
   );

   rst_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_valid && !rsp_stall),
      .room      (room),
      .not_empty (rsp_valid),
      .head      (head)
   );

   assign rsp_result_kind    = head.result_kind;
   assign rsp_stream_id      = head.stream_id;
   assign rsp_network_id     = head.network_id;
   assign rsp_service_number = head.service_number;
   assign rsp_event_number   = head.event_number;
   assign rsp_run_state      = head.run_state;
   assign rsp_entry_index    = head.entry_index;
   assign rsp_table_code     = head.table_code;
   assign rsp_length_field   = head.length_field;
   assign rsp_entries_found  = head.entries_found;
   assign rsp_parse_status   = head.parse_status;
   assign rsp_final_result   = head.final_result;

endmodule

FILE: rtl/core/rst_checker.sv
// ----------------------------------------------------------------------------
// rst_checker
// Port-level checks on the section parser's result channel.
// ----------------------------------------------------------------------------
module rst_checker import rst_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_result_kind,
   input logic [15:0] rsp_stream_id,
   input logic [15:0] rsp_network_id,
   input logic [15:0] rsp_service_number,
   input logic [15:0] rsp_event_number,
   input logic [2:0]  rsp_run_state,
   input logic [6:0]  rsp_entry_index,
   input logic [7:0]  rsp_table_code,
   input logic [11:0] rsp_length_field,
   input logic [7:0]  rsp_entries_found,
   input logic        rsp_parse_status,
   input logic        rsp_final_result
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result channel valid right after reset");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind) &&
         $stable(rsp_stream_id) && $stable(rsp_event_number) &&
         $stable(rsp_entries_found) && $stable(rsp_final_result))
      else $error("stalled transaction changed");

   a_final_is_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_final_result == (rsp_result_kind == KIND_SUMMARY)))
      else $error("final flag does not match result kind");

   a_summary_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_SUMMARY |->
         rsp_stream_id == 16'd0 && rsp_network_id == 16'd0 &&
         rsp_service_number == 16'd0 && rsp_event_number == 16'd0 &&
         rsp_run_state == 3'd0 && rsp_entry_index == 7'd0)
      else $error("summary carries entry fields");

   a_error_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parse_status == STATUS_SIZE_ERROR |->
         rsp_result_kind == KIND_SUMMARY && rsp_entries_found == 8'd0 &&
         rsp_table_code == 8'd0 && rsp_length_field == 12'd0)
      else $error("size error result carries parsed data");

endmodule

bind rst_section_parser rst_checker u_rst_checker (.*);

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for rst_section_parser. Sections are fed byte by byte.
// Each accepted byte goes through a local model of the header and record
// parser, which queues the entry and summary results it should produce.
// A monitor compares each result against the oldest queued one, field by
// field. Tests cover corner cases, random sections with random idling on
// both sides, a long output hold, and a section that reaches the entry
// limit.
// ----------------------------------------------------------------------------
module tb_top import rst_pkg::*; ();

   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte      = 8'h00;
   logic        req_first_byte     = 1'b0;
   logic        req_last_byte      = 1'b0;
   logic [11:0] req_section_bytes  = 12'h000;
   logic        rsp_valid;
   logic        rsp_stall          = 1'b0;
   logic        rsp_result_kind;
   logic [15:0] rsp_stream_id;
   logic [15:0] rsp_network_id;
   logic [15:0] rsp_service_number;
   logic [15:0] rsp_event_number;
   logic [2:0]  rsp_run_state;
   logic [6:0]  rsp_entry_index;
   logic [7:0]  rsp_table_code;
   logic [11:0] rsp_length_field;
   logic [7:0]  rsp_entries_found;
   logic        rsp_parse_status;
   logic        rsp_final_result;

   // section model state
   logic [11:0] sec_pos;
   logic [11:0] sec_remaining;
   logic [3:0]  rec_count;
   logic [63:0] rec_bits;
   logic [7:0]  hdr_table;
   logic [11:0] hdr_length;
   logic [7:0]  entry_total;
   logic        bad_size;
   logic        sec_open;

   result_type  pending_results[$];
   int          error_count    = 0;
   int          bytes_accepted = 0;
   bit          tx_gaps_on     = 1'b0;
   bit          rx_gaps_on     = 1'b0;
   int          hold_request   = 0;

   rst_section_parser #(
      .MIN_SECTION_BYTES (DEF_MIN_SECTION_BYTES),
      .MAX_SECTION_BYTES (DEF_MAX_SECTION_BYTES),
      .MAX_ENTRIES       (DEF_MAX_ENTRIES)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_first_byte     (req_first_byte),
      .req_last_byte      (req_last_byte),
      .req_section_bytes  (req_section_bytes),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_stream_id      (rsp_stream_id),
      .rsp_network_id     (rsp_network_id),
      .rsp_service_number (rsp_service_number),
      .rsp_event_number   (rsp_event_number),
      .rsp_run_state      (rsp_run_state),
      .rsp_entry_index    (rsp_entry_index),
      .rsp_table_code     (rsp_table_code),
      .rsp_length_field   (rsp_length_field),
      .rsp_entries_found  (rsp_entries_found),
      .rsp_parse_status   (rsp_parse_status),
      .rsp_final_result   (rsp_final_result)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic void clear_section();
      sec_pos       = '0;
      sec_remaining = '0;
      rec_count     = '0;
      rec_bits      = '0;
      hdr_table     = '0;
      hdr_length    = '0;
      entry_total   = '0;
      bad_size      = STATUS_OK;
   endfunction

   function automatic result_type section_fields();
      result_type r;
      r               = '0;
      r.table_code    = hdr_table;
      r.length_field  = hdr_length;
      r.entries_found = entry_total;
      r.parse_status  = bad_size;
      return r;
   endfunction

   function automatic void predict_section_byte(logic [7:0] data, logic is_first,
                                                logic is_last, logic [11:0] size);
      result_type r;
      if (is_first) begin
         clear_section();
         sec_open = 1'b1;
         bad_size = (size < DEF_MIN_SECTION_BYTES || size > DEF_MAX_SECTION_BYTES)
                    ? STATUS_SIZE_ERROR : STATUS_OK;
      end
      if (!sec_open)
         return;
      if (bad_size == STATUS_OK) begin
         if (sec_pos == POS_TABLE_ID) begin
            hdr_table = data;
         end else if (sec_pos == POS_LENGTH_HI) begin
            hdr_length = {data[3:0], 8'h00};
         end else if (sec_pos == POS_LENGTH_LO) begin
            hdr_length[7:0] = data;
            sec_remaining   = hdr_length;
         end else if (rec_count != 0 ||
                      (sec_remaining >= RECORD_BYTES && entry_total < DEF_MAX_ENTRIES)) begin
            if (rec_count < RECORD_LAST_INDEX) begin
               rec_bits  = {rec_bits[55:0], data};
               rec_count = rec_count + 4'd1;
            end else begin
               r                = section_fields();
               r.result_kind    = KIND_ENTRY;
               r.stream_id      = rec_bits[63:48];
               r.network_id     = rec_bits[47:32];
               r.service_number = rec_bits[31:16];
               r.event_number   = rec_bits[15:0];
               r.run_state      = data[2:0];
               r.entry_index    = entry_total[6:0];
               entry_total      = entry_total + 8'd1;
               r.entries_found  = entry_total;
               r.final_result   = 1'b0;
               sec_remaining    = sec_remaining - 12'(RECORD_BYTES);
               rec_count        = '0;
               rec_bits         = '0;
               pending_results.push_back(r);
            end
         end
      end
      if (sec_pos != POS_SATURATED)
         sec_pos = sec_pos + 12'd1;
      if (is_last) begin
         r              = section_fields();
         r.result_kind  = KIND_SUMMARY;
         r.final_result = 1'b1;
         pending_results.push_back(r);
         clear_section();
         sec_open = 1'b0;
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      error_count++;
      if (error_count <= 50)
         $display("mismatch on %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
   endtask

   task automatic check_result();
      result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("result with none outstanding", 16'(rsp_result_kind), 16'h0);
         return;
      end
      want = pending_results.pop_front();
      if (rsp_result_kind !== want.result_kind)
         report_mismatch("result_kind", 16'(rsp_result_kind), 16'(want.result_kind));
      if (rsp_stream_id !== want.stream_id)
         report_mismatch("stream_id", rsp_stream_id, want.stream_id);
      if (rsp_network_id !== want.network_id)
         report_mismatch("network_id", rsp_network_id, want.network_id);
      if (rsp_service_number !== want.service_number)
         report_mismatch("service_number", rsp_service_number, want.service_number);
      if (rsp_event_number !== want.event_number)
         report_mismatch("event_number", rsp_event_number, want.event_number);
      if (rsp_run_state !== want.run_state)
         report_mismatch("run_state", 16'(rsp_run_state), 16'(want.run_state));
      if (rsp_entry_index !== want.entry_index)
         report_mismatch("entry_index", 16'(rsp_entry_index), 16'(want.entry_index));
      if (rsp_table_code !== want.table_code)
         report_mismatch("table_code", 16'(rsp_table_code), 16'(want.table_code));
      if (rsp_length_field !== want.length_field)
         report_mismatch("length_field", 16'(rsp_length_field), 16'(want.length_field));
      if (rsp_entries_found !== want.entries_found)
         report_mismatch("entries_found", 16'(rsp_entries_found), 16'(want.entries_found));
      if (rsp_parse_status !== want.parse_status)
         report_mismatch("parse_status", 16'(rsp_parse_status), 16'(want.parse_status));
      if (rsp_final_result !== want.final_result)
         report_mismatch("final_result", 16'(rsp_final_result), 16'(want.final_result));
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall)
            check_result();
      end
   end

   // output stall: long hold on request, else random bursts while rx_gaps_on is set
   initial begin
      int hold_left;
      int burst_left;
      hold_left  = 0;
      burst_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!rx_gaps_on) begin
            burst_left = 0;
            rsp_stall <= 1'b0;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(0, 11);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic is_first,
                            input logic is_last, input logic [11:0] size);
      int gap;
      if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= data;
      req_first_byte    <= is_first;
      req_last_byte     <= is_last;
      req_section_bytes <= size;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      predict_section_byte(data, is_first, is_last, size);
      bytes_accepted++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_random_section();
      int          pick;
      int          records;
      int          length;
      int          total;
      int          strays;
      bit          no_close;
      logic [11:0] size;
      logic [7:0]  data;
      pick     = $urandom_range(0, 99);
      no_close = 1'b0;
      if (pick >= 28 && pick < 34) begin
         strays = $urandom_range(1, 3);
         repeat (strays)
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                      12'($urandom_range(0, 4095)));
      end
      records = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
      length  = records * RECORD_BYTES +
                (($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 4);
      if (pick >= 34 && pick < 38)
         length = $urandom_range(0, 4095);
      total = 3 + records * RECORD_BYTES + 4;
      if (total > 3 + length)
         total = 3 + length;
      size = ($urandom_range(0, 3) == 0)
             ? 12'($urandom_range(DEF_MIN_SECTION_BYTES, DEF_MAX_SECTION_BYTES))
             : 12'(total);
      if (pick < 8) begin
         size  = ($urandom_range(0, 1) == 0)
                 ? 12'($urandom_range(0, DEF_MIN_SECTION_BYTES - 1))
                 : 12'($urandom_range(DEF_MAX_SECTION_BYTES + 1, 4095));
         total = $urandom_range(1, 6);
      end else if (pick < 18) begin
         total = $urandom_range(1, total);
      end else if (pick < 23) begin
         total = total + $urandom_range(1, 10);
      end else if (pick < 28) begin
         total    = $urandom_range(1, total);
         no_close = 1'b1;
      end
      for (int i = 0; i < total; i++) begin
         if (i == 1)
            data = {4'($urandom_range(0, 15)), 4'(length >> 8)};
         else if (i == 2)
            data = 8'(length);
         else
            data = 8'($urandom_range(0, 255));
         send_byte(data, i == 0, (i == total - 1) && !no_close,
                   (i == 0) ? size : 12'($urandom_range(0, 4095)));
      end
   endtask

   task automatic test_corner_cases();
      tx_gaps_on = 1'b0;
      rx_gaps_on = 1'b0;
      send_byte(8'hFF, 1'b0, 1'b0, 12'hFFF);
      send_byte(8'h00, 1'b0, 1'b1, 12'h000);
      send_byte(8'hFF, 1'b1, 1'b1, 12'd3);
      send_byte(8'h5A, 1'b1, 1'b1, 12'd2);
      send_byte(8'hA5, 1'b1, 1'b0, 12'hFFF);
      send_byte(8'h3C, 1'b0, 1'b1, 12'h000);
      // one record ending on the last byte
      send_byte(8'h00, 1'b1, 1'b0, 12'd12);
      send_byte(8'hF0, 1'b0, 1'b0, 12'h000);
      send_byte(8'h09, 1'b0, 1'b0, 12'h000);
      send_byte(8'hFF, 1'b0, 1'b0, 12'h000);
      send_byte(8'h00, 1'b0, 1'b0, 12'h000);
      send_byte(8'h00, 1'b0, 1'b0, 12'h000);
      send_byte(8'hFF, 1'b0, 1'b0, 12'h000);
      send_byte(8'hFF, 1'b0, 1'b0, 12'h000);
      send_byte(8'h00, 1'b0, 1'b0, 12'h000);
      send_byte(8'h00, 1'b0, 1'b0, 12'h000);
      send_byte(8'hFF, 1'b0, 1'b0, 12'h000);
      send_byte(8'hFF, 1'b0, 1'b1, 12'h000);
      // drop a section mid-record, then cut the next one short
      send_byte(8'h72, 1'b1, 1'b0, 12'd1024);
      send_byte(8'h0F, 1'b0, 1'b0, 12'h000);
      send_byte(8'hFF, 1'b0, 1'b0, 12'h000);
      send_byte(8'h11, 1'b0, 1'b0, 12'h000);
      send_byte(8'h22, 1'b0, 1'b0, 12'h000);
      send_byte(8'h73, 1'b1, 1'b0, 12'd1024);
      send_byte(8'h00, 1'b0, 1'b0, 12'h000);
      send_byte(8'h12, 1'b0, 1'b0, 12'h000);
      send_byte(8'h81, 1'b0, 1'b0, 12'h000);
      send_byte(8'h42, 1'b0, 1'b0, 12'h000);
      send_byte(8'h24, 1'b0, 1'b0, 12'h000);
      send_byte(8'h18, 1'b0, 1'b1, 12'h000);
      wait_for_results();
   endtask

   task automatic test_random_sections(input int target, input bit allow_gaps);
      int start;
      start = bytes_accepted;
      while (bytes_accepted - start < target) begin
         tx_gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
         rx_gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
         send_random_section();
      end
      wait_for_results();
   endtask

   task automatic test_output_hold();
      tx_gaps_on   = 1'b0;
      rx_gaps_on   = 1'b0;
      hold_request = 200;
      send_byte(8'h71, 1'b1, 1'b0, 12'd1024);
      send_byte(8'hF0, 1'b0, 1'b0, 12'h000);
      send_byte(8'd58, 1'b0, 1'b0, 12'h000);
      for (int i = 0; i < 58; i++)
         send_byte(8'($urandom_range(0, 255)), 1'b0, i == 57, 12'h000);
      wait_for_results();
   endtask

   task automatic test_entry_limit();
      tx_gaps_on = 1'b1;
      rx_gaps_on = 1'b1;
      send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, 12'd1024);
      send_byte({4'($urandom_range(0, 15)), 4'hF}, 1'b0, 1'b0, 12'h000);
      send_byte(8'hFF, 1'b0, 1'b0, 12'h000);
      for (int i = 0; i < 1162; i++)
         send_byte(8'($urandom_range(0, 255)), 1'b0, i == 1161,
                   12'($urandom_range(0, 4095)));
      wait_for_results();
   endtask

   initial begin
      clear_section();
      sec_open = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_cases();
      test_random_sections(100, 1'b1);
      test_output_hold();
      test_entry_limit();
      test_random_sections(60, 1'b1);
      test_random_sections(40, 1'b0);
      repeat (10) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
